// File: hw/rtl/mtg_pkg.sv
// ----------------------------------------------------------------------------
// mtg_pkg
// Shared types, constants and word functions for the Mersenne twister block.
// ----------------------------------------------------------------------------
package mtg_pkg;

    localparam int unsigned STATE_WORDS  = 624;
    localparam int unsigned TWIST_OFFSET = 397;
    localparam int unsigned ADDR_W       = 10;
    localparam int unsigned STEP_W       = 11;

    localparam logic [ADDR_W-1:0] LAST_POS    = ADDR_W'(STATE_WORDS - 1);
    localparam logic [ADDR_W-1:0] END_POS     = ADDR_W'(STATE_WORDS);
    localparam logic [ADDR_W-1:0] FAR_OFFSET  = ADDR_W'(TWIST_OFFSET);
    localparam logic [ADDR_W-1:0] FAR_WRAP    = ADDR_W'(STATE_WORDS - TWIST_OFFSET);
    localparam logic [STEP_W-1:0] PASS2_STEPS = STEP_W'(STATE_WORDS - 1);
    localparam logic [STEP_W-1:0] MIN_STEPS   = STEP_W'(STATE_WORDS);

    localparam logic [31:0] MULT_LIN  = 32'h6C07_8965;
    localparam logic [31:0] BASE_SEED = 32'h54FF_C97A;
    localparam logic [31:0] MULT_MIX1 = 32'h0019_660D;
    localparam logic [31:0] MULT_MIX2 = 32'h5D58_8B65;
    localparam logic [31:0] WORD0_SET = 32'h8000_0000;
    localparam logic [31:0] MT_MATRIX = 32'h9908_B0DF;
    localparam logic [31:0] MT_UPPER  = 32'h8000_0000;
    localparam logic [31:0] MT_LOWER  = 32'h7FFF_FFFF;

    localparam logic [1:0] REQ_SEED = 2'd0;
    localparam logic [1:0] REQ_KEY  = 2'd1;
    localparam logic [1:0] REQ_DRAW = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_BASE_START, S_LIN_MUL, S_LIN_WR, S_MIX_INIT, S_MIX_RD, S_MIX_WR,
        S_WRAP, S_PASS2, S_FORCE0, S_TW_INIT, S_TW_LOAD, S_TW_RD, S_TW_WR,
        S_DRAW_RD, S_DRAW_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NOP, OP_LIN_START, OP_LIN_MUL, OP_LIN_WR, OP_MIX_INIT, OP_MIX_RD, OP_MIX_WR,
        OP_WRAP, OP_PASS2, OP_FORCE0, OP_TW_INIT, OP_TW_LOAD, OP_TW_RD, OP_TW_WR,
        OP_DRAW_RD, OP_DRAW_OUT, OP_KEY_WR
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   pass2;
        logic   use_base;
    } dp_cmd_t;

    typedef struct packed {
        logic lin_last;
        logic wrap;
        logic pass_done;
        logic tw_last;
        logic need_twist;
        logic out_free;
    } dp_stat_t;

    function automatic logic [31:0] fold30(input logic [31:0] w);
        return w ^ (w >> 30);
    endfunction

    function automatic logic [31:0] twist_one(input logic [31:0] a, input logic [31:0] b,
                                              input logic [31:0] far);
        logic [31:0] m;
        m = (a & MT_UPPER) | (b & MT_LOWER);
        return far ^ (m >> 1) ^ (m[0] ? MT_MATRIX : 32'h0);
    endfunction

    function automatic logic [31:0] temper(input logic [31:0] w_in);
        logic [31:0] w;
        w = w_in;
        w = w ^ (w >> 11);
        w = w ^ ((w << 7) & 32'h9D2C_5680);
        w = w ^ ((w << 15) & 32'hEFC6_0000);
        w = w ^ (w >> 18);
        return w;
    endfunction

endpackage

// File: hw/rtl/mersenne_twister_generator.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator
// MT19937 generator with one-word seeding, key-array seeding and draws.
// ----------------------------------------------------------------------------
// draw: read in S_DRAW_RD, tempered out in S_DRAW_OUT, held while the output
//   stalls; a draw at the end of the state first twists all 624 words
// seed word: busy while words 1 to 623 fill; last of n key words: busy for the
//   base fill, max(n,624) mix steps, one step per wrap, 623 pass-2 steps, word 0 set
// reset: controller idle, key count zero, read index at end of state so the
//   first draw twists; state and key memories are not cleared
module mersenne_twister_generator #(
    parameter int unsigned MAX_KEY_WORDS = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] value,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] random_word
);

    // command and status between sequencer and datapath
    mtg_pkg::dp_cmd_t  cmd;
    mtg_pkg::dp_stat_t stat;

    // sequencer: accepts one transfer at a time, then steps the datapath
    mtg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .req_type (req_type),
        .last     (last),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: state memory, key store, multiplier and output register
    mtg_datapath #(
        .MAX_KEY_WORDS (MAX_KEY_WORDS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word)
    );

endmodule

// File: hw/rtl/mtg_ctrl.sv
// ----------------------------------------------------------------------------
// mtg_ctrl
// Sequencer for seeding, array seeding, twist and draw.
// ----------------------------------------------------------------------------
module mtg_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       req_type,
    input  logic             last,
    input  mtg_pkg::dp_stat_t stat,
    output mtg_pkg::dp_cmd_t cmd
);

    mtg_pkg::state_t state_reg, state_next;
    logic arr_reg, arr_next;
    logic pass2_reg, pass2_next;
    logic accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mtg_pkg::S_IDLE;
            arr_reg   <= 1'b0;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            arr_reg   <= arr_next;
            pass2_reg <= pass2_next;
        end
    end

    assign in_ready = (state_reg == mtg_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next   = state_reg;
        arr_next     = arr_reg;
        pass2_next   = pass2_reg;
        cmd.op       = mtg_pkg::OP_NOP;
        cmd.pass2    = pass2_reg;
        cmd.use_base = 1'b0;
        unique case (state_reg)
            mtg_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == mtg_pkg::REQ_SEED)
                    begin
                        cmd.op     = mtg_pkg::OP_LIN_START;
                        arr_next   = 1'b0;
                        state_next = mtg_pkg::S_LIN_MUL;
                    end
                    else if (req_type == mtg_pkg::REQ_KEY)
                    begin
                        cmd.op = mtg_pkg::OP_KEY_WR;
                        if (last)
                        begin
                            arr_next   = 1'b1;
                            state_next = mtg_pkg::S_BASE_START;
                        end
                    end
                    else if (req_type == mtg_pkg::REQ_DRAW)
                    begin
                        state_next = stat.need_twist ? mtg_pkg::S_TW_INIT
                                                     : mtg_pkg::S_DRAW_RD;
                    end
                end
            end
            mtg_pkg::S_BASE_START:
            begin
                cmd.op       = mtg_pkg::OP_LIN_START;
                cmd.use_base = 1'b1;
                state_next   = mtg_pkg::S_LIN_MUL;
            end
            mtg_pkg::S_LIN_MUL:
            begin
                cmd.op     = mtg_pkg::OP_LIN_MUL;
                state_next = mtg_pkg::S_LIN_WR;
            end
            mtg_pkg::S_LIN_WR:
            begin
                cmd.op = mtg_pkg::OP_LIN_WR;
                if (stat.lin_last)
                    state_next = arr_reg ? mtg_pkg::S_MIX_INIT : mtg_pkg::S_IDLE;
                else
                    state_next = mtg_pkg::S_LIN_MUL;
            end
            mtg_pkg::S_MIX_INIT:
            begin
                cmd.op     = mtg_pkg::OP_MIX_INIT;
                pass2_next = 1'b0;
                state_next = mtg_pkg::S_MIX_RD;
            end
            mtg_pkg::S_MIX_RD:
            begin
                cmd.op     = mtg_pkg::OP_MIX_RD;
                state_next = mtg_pkg::S_MIX_WR;
            end
            mtg_pkg::S_MIX_WR, mtg_pkg::S_WRAP:
            begin
                cmd.op = (state_reg == mtg_pkg::S_WRAP) ? mtg_pkg::OP_WRAP
                                                         : mtg_pkg::OP_MIX_WR;
                if (state_reg == mtg_pkg::S_MIX_WR && stat.wrap)
                    state_next = mtg_pkg::S_WRAP;
                else if (stat.pass_done)
                    state_next = pass2_reg ? mtg_pkg::S_FORCE0 : mtg_pkg::S_PASS2;
                else
                    state_next = mtg_pkg::S_MIX_RD;
            end
            mtg_pkg::S_PASS2:
            begin
                cmd.op     = mtg_pkg::OP_PASS2;
                pass2_next = 1'b1;
                state_next = mtg_pkg::S_MIX_RD;
            end
            mtg_pkg::S_FORCE0:
            begin
                cmd.op     = mtg_pkg::OP_FORCE0;
                state_next = mtg_pkg::S_IDLE;
            end
            mtg_pkg::S_TW_INIT:
            begin
                cmd.op     = mtg_pkg::OP_TW_INIT;
                state_next = mtg_pkg::S_TW_LOAD;
            end
            mtg_pkg::S_TW_LOAD:
            begin
                cmd.op     = mtg_pkg::OP_TW_LOAD;
                state_next = mtg_pkg::S_TW_RD;
            end
            mtg_pkg::S_TW_RD:
            begin
                cmd.op     = mtg_pkg::OP_TW_RD;
                state_next = mtg_pkg::S_TW_WR;
            end
            mtg_pkg::S_TW_WR:
            begin
                cmd.op     = mtg_pkg::OP_TW_WR;
                state_next = stat.tw_last ? mtg_pkg::S_DRAW_RD : mtg_pkg::S_TW_RD;
            end
            mtg_pkg::S_DRAW_RD:
            begin
                cmd.op     = mtg_pkg::OP_DRAW_RD;
                state_next = mtg_pkg::S_DRAW_OUT;
            end
            mtg_pkg::S_DRAW_OUT:
            begin
                // hold until the output register is free
                if (stat.out_free)
                begin
                    cmd.op     = mtg_pkg::OP_DRAW_OUT;
                    state_next = mtg_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = mtg_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/mtg_datapath.sv
// ----------------------------------------------------------------------------
// mtg_datapath
// State memory, key store, multiplier, twist and tempering datapath.
// ----------------------------------------------------------------------------
module mtg_datapath #(
    parameter int unsigned MAX_KEY_WORDS = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mtg_pkg::dp_cmd_t cmd,
    output mtg_pkg::dp_stat_t stat,
    input  logic [31:0]      value,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      random_word
);

    localparam int unsigned KIDX_W = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
    localparam int unsigned CNT_W  = $clog2(MAX_KEY_WORDS + 1);
    localparam logic [CNT_W-1:0] KEY_FULL = CNT_W'(MAX_KEY_WORDS);

    localparam int unsigned AW = mtg_pkg::ADDR_W;
    localparam int unsigned SW = mtg_pkg::STEP_W;

    logic [31:0] state_mem [mtg_pkg::STATE_WORDS];
    logic [31:0] key_mem   [MAX_KEY_WORDS];

    logic [31:0]       rd_a_reg, rd_b_reg, key_rd_reg;
    logic [31:0]       prev_reg, cur_reg, prod_reg, out_reg;
    logic              out_valid_reg;
    logic [AW-1:0]     pos_reg, idx_reg;
    logic [KIDX_W-1:0] kk_reg;
    logic [SW-1:0]     step_reg;
    logic [CNT_W-1:0]  key_count_reg;

    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [31:0]       wr_data;
    logic              rd_a_en, rd_b_en;
    logic [AW-1:0]     rd_a_addr, rd_b_addr;
    logic [AW-1:0]     nxt_pos, far_pos;
    logic [31:0]       lin_word, mix_word, tw_word, mult_k;
    logic [CNT_W-1:0]  kk_inc;
    logic [SW-1:0]     steps;

    assign nxt_pos  = (pos_reg == mtg_pkg::LAST_POS) ? '0 : pos_reg + AW'(1);
    assign far_pos  = (pos_reg >= mtg_pkg::FAR_WRAP) ? pos_reg - mtg_pkg::FAR_WRAP
                                                     : pos_reg + mtg_pkg::FAR_OFFSET;
    assign lin_word = prod_reg + 32'(pos_reg);
    assign mix_word = cmd.pass2 ? ((rd_a_reg ^ prod_reg) - 32'(pos_reg))
                                : ((rd_a_reg ^ prod_reg) + key_rd_reg + 32'(kk_reg));
    assign tw_word  = mtg_pkg::twist_one(cur_reg, rd_a_reg, rd_b_reg);
    assign kk_inc   = CNT_W'(kk_reg) + CNT_W'(1);
    assign steps    = (SW'(key_count_reg) > mtg_pkg::MIN_STEPS) ? SW'(key_count_reg)
                                                                : mtg_pkg::MIN_STEPS;
    assign mult_k   = (cmd.op == mtg_pkg::OP_LIN_MUL) ? mtg_pkg::MULT_LIN
                    : (cmd.pass2 ? mtg_pkg::MULT_MIX2 : mtg_pkg::MULT_MIX1);

    // memory port control
    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = pos_reg;
        wr_data   = mix_word;
        rd_a_en   = 1'b0;
        rd_b_en   = 1'b0;
        rd_a_addr = pos_reg;
        rd_b_addr = far_pos;
        case (cmd.op)
            mtg_pkg::OP_LIN_START:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = cmd.use_base ? mtg_pkg::BASE_SEED : value;
            end
            mtg_pkg::OP_LIN_WR:
            begin
                wr_en   = 1'b1;
                wr_data = lin_word;
            end
            mtg_pkg::OP_MIX_RD:
            begin
                rd_a_en = 1'b1;
            end
            mtg_pkg::OP_MIX_WR:
            begin
                wr_en = 1'b1;
            end
            mtg_pkg::OP_WRAP:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = prev_reg;
            end
            mtg_pkg::OP_FORCE0:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = mtg_pkg::WORD0_SET;
            end
            mtg_pkg::OP_TW_INIT:
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = '0;
            end
            mtg_pkg::OP_TW_RD:
            begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = nxt_pos;
            end
            mtg_pkg::OP_TW_WR:
            begin
                wr_en   = 1'b1;
                wr_data = tw_word;
            end
            mtg_pkg::OP_DRAW_RD:
            begin
                rd_a_en   = 1'b1;
                rd_a_addr = idx_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            state_mem[wr_addr] <= wr_data;
        if (rd_a_en)
            rd_a_reg <= state_mem[rd_a_addr];
        if (rd_b_en)
            rd_b_reg <= state_mem[rd_b_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == mtg_pkg::OP_KEY_WR && key_count_reg != KEY_FULL)
            key_mem[key_count_reg[KIDX_W-1:0]] <= value;
        if (cmd.op == mtg_pkg::OP_MIX_RD)
            key_rd_reg <= key_mem[kk_reg];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.op == mtg_pkg::OP_LIN_MUL || cmd.op == mtg_pkg::OP_MIX_RD)
            prod_reg <= mtg_pkg::fold30(prev_reg) * mult_k;
        case (cmd.op)
            mtg_pkg::OP_LIN_START: prev_reg <= wr_data;
            mtg_pkg::OP_LIN_WR:    prev_reg <= lin_word;
            mtg_pkg::OP_MIX_INIT:  prev_reg <= mtg_pkg::BASE_SEED;
            mtg_pkg::OP_MIX_WR:    prev_reg <= mix_word;
            default:               prev_reg <= prev_reg;
        endcase
        if (cmd.op == mtg_pkg::OP_TW_LOAD || cmd.op == mtg_pkg::OP_TW_WR)
            cur_reg <= rd_a_reg;
        if (cmd.op == mtg_pkg::OP_DRAW_OUT)
            out_reg <= mtg_pkg::temper(rd_a_reg);
    end

    // counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
            idx_reg       <= mtg_pkg::END_POS;
            kk_reg        <= '0;
            step_reg      <= '0;
            key_count_reg <= '0;
        end
        else
        begin
            if (cmd.op == mtg_pkg::OP_DRAW_OUT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (cmd.op)
                mtg_pkg::OP_LIN_START:
                begin
                    pos_reg <= AW'(1);
                    idx_reg <= mtg_pkg::END_POS;
                end
                mtg_pkg::OP_LIN_WR:
                begin
                    pos_reg <= pos_reg + AW'(1);
                end
                mtg_pkg::OP_MIX_INIT:
                begin
                    pos_reg  <= AW'(1);
                    kk_reg   <= '0;
                    step_reg <= '0;
                end
                mtg_pkg::OP_MIX_RD:
                begin
                    step_reg <= step_reg + SW'(1);
                end
                mtg_pkg::OP_MIX_WR:
                begin
                    pos_reg <= pos_reg + AW'(1);
                    kk_reg  <= (kk_inc >= key_count_reg) ? '0 : kk_inc[KIDX_W-1:0];
                end
                mtg_pkg::OP_WRAP:
                begin
                    pos_reg <= AW'(1);
                end
                mtg_pkg::OP_PASS2:
                begin
                    step_reg <= '0;
                end
                mtg_pkg::OP_FORCE0:
                begin
                    key_count_reg <= '0;
                end
                mtg_pkg::OP_TW_INIT:
                begin
                    pos_reg <= '0;
                end
                mtg_pkg::OP_TW_WR:
                begin
                    pos_reg <= nxt_pos;
                    if (pos_reg == mtg_pkg::LAST_POS)
                        idx_reg <= '0;
                end
                mtg_pkg::OP_DRAW_OUT:
                begin
                    idx_reg <= idx_reg + AW'(1);
                end
                mtg_pkg::OP_KEY_WR:
                begin
                    if (key_count_reg != KEY_FULL)
                        key_count_reg <= key_count_reg + CNT_W'(1);
                end
                default:
                begin
                    pos_reg <= pos_reg;
                end
            endcase
        end
    end

    assign stat.lin_last   = (pos_reg == mtg_pkg::LAST_POS);
    assign stat.wrap       = (pos_reg == mtg_pkg::LAST_POS);
    assign stat.pass_done  = cmd.pass2 ? (step_reg == mtg_pkg::PASS2_STEPS)
                                       : (step_reg == steps);
    assign stat.tw_last    = (pos_reg == mtg_pkg::LAST_POS);
    assign stat.need_twist = (idx_reg >= mtg_pkg::END_POS);
    assign stat.out_free   = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign random_word = out_reg;

endmodule

// File: hw/rtl/mtg_checker.sv
// ----------------------------------------------------------------------------
// mtg_checker
// Port-level checks for the Mersenne twister block.
// ----------------------------------------------------------------------------
module mtg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [1:0]  req_type,
    input logic        last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] random_word
);

    // result held while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(random_word))
        else $error("result changed while stalled");

    // a new result only appears while the block is busy with a draw
    a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result appeared without a draw in progress");

    // seeding keeps the input side closed
    a_seed_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == mtg_pkg::REQ_SEED |=> !in_ready)
        else $error("input open right after a seed");

    a_key_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && req_type == mtg_pkg::REQ_KEY && last |=> !in_ready)
        else $error("input open right after the last key word");

endmodule

bind mersenne_twister_generator mtg_checker u_mtg_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .last        (last),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .random_word (random_word)
);

// File: tb/mersenne_twister_generator_tb.sv
// ----------------------------------------------------------------------------
// mersenne_twister_generator_tb
// Self-checking bench: seeds, key-array seeding and draws are sent in bursts,
// each draw word is predicted by a behavioral twister and compared in order.
// ----------------------------------------------------------------------------
module mersenne_twister_generator_tb;

    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam int         KEY_DEPTH  = 64;
    localparam int         N_RANDOM   = 1220;
    // drain well past the longest seeding run
    localparam int         DRAIN_CYCLES = 6000;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [31:0] value;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] random_word;

    // behavioral twister state
    logic [31:0] mt_words [mtg_pkg::STATE_WORDS];
    int unsigned mt_pos;
    logic [31:0] key_words [KEY_DEPTH];
    int unsigned key_total;

    logic [31:0] draw_words_q [$];
    int          error_count;
    int          burst_left;
    int          ready_left;
    bit          ready_on;

    mersenne_twister_generator #(.MAX_KEY_WORDS(KEY_DEPTH)) uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .value       (value),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .random_word (random_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // hard stop in case the block hangs
    initial
    begin
        #20000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] xor_high(input logic [31:0] w);
        return w ^ (w >> 30);
    endfunction

    function automatic logic [31:0] tempered(input logic [31:0] w_in);
        logic [31:0] w;
        w = w_in ^ (w_in >> 11);
        w = w ^ ((w << 7) & 32'h9D2C_5680);
        w = w ^ ((w << 15) & 32'hEFC6_0000);
        return w ^ (w >> 18);
    endfunction

    task automatic fill_linear(input logic [31:0] s);
        mt_words[0] = s;
        for (int k = 1; k < mtg_pkg::STATE_WORDS; k++)
        begin
            mt_words[k] = 32'h6C07_8965 * xor_high(mt_words[k-1]) + 32'(k);
        end
        mt_pos = mtg_pkg::STATE_WORDS;
    endtask

    task automatic fill_from_keys(input int unsigned n);
        int unsigned p;
        int unsigned kk;
        int unsigned steps;
        p = 1;
        kk = 0;
        fill_linear(32'h54FF_C97A);
        steps = (n > mtg_pkg::STATE_WORDS) ? n : mtg_pkg::STATE_WORDS;
        for (int unsigned r = 0; r < steps; r++)
        begin
            mt_words[p] = (mt_words[p] ^ (xor_high(mt_words[p-1]) * 32'h0019_660D))
                          + key_words[kk] + 32'(kk);
            p++;
            kk++;
            if (p >= mtg_pkg::STATE_WORDS)
            begin
                mt_words[0] = mt_words[mtg_pkg::STATE_WORDS-1];
                p = 1;
            end
            if (kk >= n)
                kk = 0;
        end
        for (int unsigned r = 0; r < mtg_pkg::STATE_WORDS - 1; r++)
        begin
            mt_words[p] = (mt_words[p] ^ (xor_high(mt_words[p-1]) * 32'h5D58_8B65))
                          - 32'(p);
            p++;
            if (p >= mtg_pkg::STATE_WORDS)
            begin
                mt_words[0] = mt_words[mtg_pkg::STATE_WORDS-1];
                p = 1;
            end
        end
        mt_words[0] = 32'h8000_0000;
    endtask

    task automatic twist_state();
        logic [31:0] m;
        for (int k = 0; k < mtg_pkg::STATE_WORDS; k++)
        begin
            m = (mt_words[k] & 32'h8000_0000)
                | (mt_words[(k + 1) % mtg_pkg::STATE_WORDS] & 32'h7FFF_FFFF);
            mt_words[k] = mt_words[(k + mtg_pkg::TWIST_OFFSET) % mtg_pkg::STATE_WORDS]
                          ^ (m >> 1) ^ (m[0] ? 32'h9908_B0DF : 32'h0);
        end
        mt_pos = 0;
    endtask

    // update the twister for one accepted transfer, queue the word of a draw
    task automatic apply_request(input logic [1:0] rq, input logic [31:0] v,
                                 input logic fin);
        case (rq)
            mtg_pkg::REQ_SEED:
                fill_linear(v);
            mtg_pkg::REQ_KEY:
            begin
                if (key_total < KEY_DEPTH)
                begin
                    key_words[key_total] = v;
                    key_total++;
                end
                if (fin && key_total > 0)
                begin
                    fill_from_keys(key_total);
                    key_total = 0;
                end
            end
            mtg_pkg::REQ_DRAW:
            begin
                if (mt_pos >= mtg_pkg::STATE_WORDS)
                    twist_state();
                draw_words_q.push_back(tempered(mt_words[mt_pos]));
                mt_pos++;
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch: %s got %08h want %08h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // one transfer; entered and left just after a rising edge
    task automatic send_item(input logic [1:0] rq, input logic [31:0] v, input logic fin);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 3) != 0)
            begin
                in_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        req_type <= rq;
        value    <= v;
        last     <= fin;
        do @(posedge clk); while (!in_ready);
        apply_request(rq, v, fin);
    endtask

    task automatic draw_some(input int n);
        for (int i = 0; i < n; i++)
            send_item(mtg_pkg::REQ_DRAW, $urandom, 1'($urandom_range(0, 1)));
    endtask

    // receiver stalls on its own run/stall pattern
    always @(posedge clk)
    begin
        if (ready_left == 0)
        begin
            ready_on   = ($urandom_range(0, 2) != 0);
            ready_left = ready_on ? $urandom_range(1, 40) : $urandom_range(1, 12);
        end
        ready_left--;
        out_ready <= ready_on;
    end

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (draw_words_q.size() == 0)
                report("unexpected random_word", random_word, 32'h0);
            else
            begin
                if (random_word !== draw_words_q[0])
                    report("random_word", random_word, draw_words_q[0]);
                void'(draw_words_q.pop_front());
            end
        end
    end

    // one-word seeding at the value extremes, ignored flags and the spare code
    task automatic test_word_seed();
        send_item(mtg_pkg::REQ_SEED, 32'h0000_0000, 1'b1);
        draw_some(3);
        send_item(mtg_pkg::REQ_SEED, 32'hFFFF_FFFF, 1'b0);
        draw_some(2);
        send_item(REQ_UNUSED, 32'hA5A5_5A5A, 1'b1);
        send_item(REQ_UNUSED, 32'h5A5A_A5A5, 1'b0);
        draw_some(2);
    endtask

    // key-array seeding, including a reseed while key words are pending
    task automatic test_key_seed();
        send_item(mtg_pkg::REQ_KEY, 32'h1234_5678, 1'b1);
        draw_some(2);
        send_item(mtg_pkg::REQ_KEY, 32'h0000_0000, 1'b0);
        send_item(mtg_pkg::REQ_KEY, 32'hFFFF_FFFF, 1'b0);
        send_item(mtg_pkg::REQ_KEY, 32'h8000_0001, 1'b1);
        draw_some(2);
        send_item(mtg_pkg::REQ_KEY, 32'hDEAD_BEEF, 1'b0);
        send_item(mtg_pkg::REQ_SEED, 32'h0BAD_F00D, 1'b0);
        draw_some(1);
        send_item(mtg_pkg::REQ_KEY, 32'h7FFF_FFFF, 1'b1);
        draw_some(2);
    endtask

    // more key words than the store holds; last one is dropped but still seeds
    task automatic test_key_overflow();
        for (int i = 0; i < KEY_DEPTH + 5; i++)
            send_item(mtg_pkg::REQ_KEY, $urandom, 1'(i == KEY_DEPTH + 4));
        draw_some(2);
    endtask

    // mostly draws so twists come often, with seeds, key runs and noise
    task automatic test_random_mix();
        int pick;
        int nkeys;
        for (int i = 0; i < N_RANDOM; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 85)
                draw_some(1);
            else if (pick < 89)
                send_item(mtg_pkg::REQ_SEED, $urandom, 1'($urandom_range(0, 1)));
            else if (pick < 97)
            begin
                // a short key run, usually closed by a last flag
                nkeys = $urandom_range(1, 4);
                for (int k = 0; k < nkeys; k++)
                    send_item(mtg_pkg::REQ_KEY, $urandom,
                              1'(k == nkeys - 1 && $urandom_range(0, 4) != 0));
            end
            else
                send_item(REQ_UNUSED, $urandom, 1'($urandom_range(0, 1)));
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        req_type   = mtg_pkg::REQ_SEED;
        value      = 32'h0;
        last       = 1'b0;
        out_ready  = 1'b0;
        error_count = 0;
        burst_left = 0;
        ready_left = 0;
        ready_on   = 1'b0;
        key_total  = 0;
        mt_pos     = mtg_pkg::STATE_WORDS;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // the state is never read before the first seeding
        test_word_seed();
        test_key_seed();
        test_key_overflow();
        test_random_mix();

        in_valid <= 1'b0;
        while (draw_words_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/mtg_pkg.sv
hw/rtl/mtg_ctrl.sv
hw/rtl/mtg_datapath.sv
hw/rtl/mersenne_twister_generator.sv
hw/rtl/mtg_checker.sv
tb/mersenne_twister_generator_tb.sv
